// ===== rtl/sorted_deadline_timer_queue_macros.svh =====
`ifndef SORTED_DEADLINE_TIMER_QUEUE_MACROS_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SDTQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define SDTQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sdtq_pkg.sv =====
`timescale 1ns / 1ps

package sdtq_pkg;

  localparam int unsigned SecW     = 32;
  localparam int unsigned DelayW   = 16;
  localparam int unsigned IdW      = 8;
  localparam int unsigned TmoW     = 16;
  localparam int unsigned OpW      = 2;
  localparam int unsigned MaxFire  = 16;
  localparam int unsigned FireCntW = 4;

  typedef enum logic [OpW-1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  localparam logic KIND_FIRED  = 1'b0;
  localparam logic KIND_ACK    = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // One timer entry as held in a slot.
  typedef struct packed {
    logic            valid;
    logic [SecW-1:0] deadline;
    logic [IdW-1:0]  owner;
  } entry_t;

  // Command broadcast to every slot.
  typedef struct packed {
    logic            shift;
    logic            insert;
    logic [SecW-1:0] deadline;
    logic [IdW-1:0]  owner;
  } slot_cmd_t;

endpackage

// ===== rtl/sorted_deadline_timer_queue.sv =====
`timescale 1ns / 1ps
// Channel  | Handshake               | Payload
// ---------+-------------------------+---------------------------------------------
// request  | in_valid_i / in_ready_o | operation_i, delay_i, task_id_i
// result   | out_valid_o/out_ready_i | kind_o, fired_id_o, status_o,
//          |                         | queue_nonempty_o, min_timeout_o, last_o
//
// One request at a time: a tick fires due entries in turn, head first, or
// acknowledges when none is due; add latches, inserts, then acknowledges;
// delete walks the pending entries, then acknowledges; an unknown operation is
// acknowledged. in_ready_o is high only while the sequencer is idle; a stalled
// result holds the sequencer in place. Reset clears the second counter, state,
// fire count, position, result valid and slot valid bits only.

module sorted_deadline_timer_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sdtq_pkg::OpW-1:0]      operation_i,
  input  logic [sdtq_pkg::DelayW-1:0]   delay_i,
  input  logic [sdtq_pkg::IdW-1:0]      task_id_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          kind_o,
  output logic [sdtq_pkg::IdW-1:0]      fired_id_o,
  output logic                          status_o,
  output logic                          queue_nonempty_o,
  output logic [sdtq_pkg::TmoW-1:0]     min_timeout_o,
  output logic                          last_o
);

  `include "sorted_deadline_timer_queue_macros.svh"

  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned PosW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_INSERT = 5'b00010,
    ST_FIRE   = 5'b00100,
    ST_DELETE = 5'b01000,
    ST_ACK    = 5'b10000
  } state_e;

  state_e                            state_q, state_d;
  logic [sdtq_pkg::SecW-1:0]         sec_q, sec_d;
  logic [sdtq_pkg::SecW-1:0]         new_dl_q, new_dl_d;
  logic [sdtq_pkg::IdW-1:0]          id_q, id_d;
  logic                              status_q, status_d;
  logic [sdtq_pkg::FireCntW-1:0]     fire_cnt_q, fire_cnt_d;
  logic [PosW-1:0]                   pos_q, pos_d;

  // Output register
  logic                              out_valid_q, out_valid_d;
  logic                              kind_q, kind_d;
  logic [sdtq_pkg::IdW-1:0]          fired_id_q, fired_id_d;
  logic                              out_status_q, out_status_d;
  logic                              nonempty_q, nonempty_d;
  logic [sdtq_pkg::TmoW-1:0]         tmo_q, tmo_d;
  logic                              last_q, last_d;

  sdtq_pkg::slot_cmd_t               cmd;
  sdtq_pkg::entry_t                  slot_ent [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]            slot_keep;
  logic [QUEUE_DEPTH-1:0]            shift_sel;
  logic [QUEUE_DEPTH-1:0]            valid_vec;

  // Slot chain: slot 0 is the head, entries stay packed and sorted.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
    sdtq_pkg::entry_t left_ent;
    sdtq_pkg::entry_t right_ent;
    logic             left_keep;

    if (i == 0) begin : g_head
      assign left_ent  = '0;
      assign left_keep = 1'b1;
    end else begin : g_body
      assign left_ent  = slot_ent[i-1];
      assign left_keep = slot_keep[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = slot_ent[i+1];
    end

    assign shift_sel[i] = (PosW'(i) >= pos_q);
    assign valid_vec[i] = slot_ent[i].valid;

    sdtq_cell u_slot (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .shift_sel_i (shift_sel[i]),
      .left_i      (left_ent),
      .left_keep_i (left_keep),
      .right_i     (right_ent),
      .entry_o     (slot_ent[i]),
      .keep_o      (slot_keep[i])
    );
  end

  logic                          out_free;
  logic                          head_due;
  logic                          next_due;
  logic                          fire_last;
  logic                          full;
  logic [sdtq_pkg::SecW:0]       dl_sum;
  logic [sdtq_pkg::SecW-1:0]     head_diff;
  logic [sdtq_pkg::TmoW-1:0]     ack_tmo;
  sdtq_pkg::entry_t              at_pos;
  logic                          pos_end;
  logic                          front_both_valid;
  logic                          front_in_order;
  logic                          burst_open;

  assign out_free  = !out_valid_q || out_ready_i;
  assign head_due  = slot_ent[0].valid && (slot_ent[0].deadline <= sec_q);
  assign next_due  = slot_ent[1].valid && (slot_ent[1].deadline <= sec_q);
  // Mark the last fired result: fire cap reached or the next head is not due.
  assign fire_last = (fire_cnt_q == sdtq_pkg::FireCntW'(sdtq_pkg::MaxFire - 1)) || !next_due;
  assign full      = slot_ent[QUEUE_DEPTH-1].valid;

  // Saturate the new deadline at the top of the counter range.
  assign dl_sum    = {1'b0, sec_q} + (sdtq_pkg::SecW + 1)'(delay_i);

  // Seconds left until the head fires, clamped to the result width.
  assign head_diff = slot_ent[0].deadline - sec_q;
  always_comb begin
    if (!slot_ent[0].valid || (slot_ent[0].deadline <= sec_q)) begin
      ack_tmo = '0;
    end else if (|head_diff[sdtq_pkg::SecW-1:sdtq_pkg::TmoW]) begin
      ack_tmo = '1;
    end else begin
      ack_tmo = head_diff[sdtq_pkg::TmoW-1:0];
    end
  end

  assign at_pos  = slot_ent[pos_q[IdxW-1:0]];
  assign pos_end = (pos_q == PosW'(QUEUE_DEPTH)) || !at_pos.valid;

  always_comb begin
    state_d      = state_q;
    sec_d        = sec_q;
    new_dl_d     = new_dl_q;
    id_d         = id_q;
    status_d     = status_q;
    fire_cnt_d   = fire_cnt_q;
    pos_d        = pos_q;
    in_ready_o   = 1'b0;

    cmd.shift    = 1'b0;
    cmd.insert   = 1'b0;
    cmd.deadline = new_dl_q;
    cmd.owner    = id_q;

    out_valid_d  = out_valid_q && !out_ready_i;
    kind_d       = kind_q;
    fired_id_d   = fired_id_q;
    out_status_d = out_status_q;
    nonempty_d   = nonempty_q;
    tmo_d        = tmo_q;
    last_d       = last_q;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (operation_i)
            sdtq_pkg::OP_TICK: begin
              if (sec_q != '1) begin
                sec_d = sec_q + 1'b1;
              end
              fire_cnt_d = '0;
              pos_d      = '0;
              state_d    = ST_FIRE;
            end
            sdtq_pkg::OP_ADD: begin
              new_dl_d = dl_sum[sdtq_pkg::SecW] ? '1 : dl_sum[sdtq_pkg::SecW-1:0];
              id_d     = task_id_i;
              state_d  = ST_INSERT;
            end
            sdtq_pkg::OP_DELETE: begin
              id_d    = task_id_i;
              pos_d   = '0;
              state_d = ST_DELETE;
            end
            default: begin
              // Unknown operation: acknowledge with no change.
              status_d = sdtq_pkg::STATUS_OK;
              state_d  = ST_ACK;
            end
          endcase
        end
      end

      ST_INSERT: begin
        if (full) begin
          status_d = sdtq_pkg::STATUS_FULL;
        end else begin
          cmd.insert = 1'b1;
          status_d   = sdtq_pkg::STATUS_OK;
        end
        state_d = ST_ACK;
      end

      ST_FIRE: begin
        if (head_due) begin
          if (out_free) begin
            // Pop the head: every slot takes its right neighbor.
            cmd.shift    = 1'b1;
            out_valid_d  = 1'b1;
            kind_d       = sdtq_pkg::KIND_FIRED;
            fired_id_d   = slot_ent[0].owner;
            out_status_d = sdtq_pkg::STATUS_OK;
            nonempty_d   = slot_ent[1].valid;
            tmo_d        = '0;
            last_d       = fire_last;
            if (fire_last) begin
              state_d = ST_IDLE;
            end else begin
              fire_cnt_d = fire_cnt_q + 1'b1;
            end
          end
        end else begin
          // Nothing due on this tick.
          status_d = sdtq_pkg::STATUS_OK;
          state_d  = ST_ACK;
        end
      end

      ST_DELETE: begin
        if (pos_end) begin
          status_d = sdtq_pkg::STATUS_OK;
          state_d  = ST_ACK;
        end else if (at_pos.owner == id_q) begin
          // Drop the matching entry; slots at and after it move left.
          cmd.shift = 1'b1;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end

      ST_ACK: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          kind_d       = sdtq_pkg::KIND_ACK;
          fired_id_d   = '0;
          out_status_d = status_q;
          nonempty_d   = slot_ent[0].valid;
          tmo_d        = ack_tmo;
          last_d       = 1'b1;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sec_q       <= '0;
      out_valid_q <= 1'b0;
      fire_cnt_q  <= '0;
      pos_q       <= '0;
    end else begin
      state_q     <= state_d;
      sec_q       <= sec_d;
      out_valid_q <= out_valid_d;
      fire_cnt_q  <= fire_cnt_d;
      pos_q       <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_dl_q     <= new_dl_d;
    id_q         <= id_d;
    status_q     <= status_d;
    kind_q       <= kind_d;
    fired_id_q   <= fired_id_d;
    out_status_q <= out_status_d;
    nonempty_q   <= nonempty_d;
    tmo_q        <= tmo_d;
    last_q       <= last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign fired_id_o       = fired_id_q;
  assign status_o         = out_status_q;
  assign queue_nonempty_o = nonempty_q;
  assign min_timeout_o    = tmo_q;
  assign last_o           = last_q;

  assign front_both_valid = slot_ent[0].valid && slot_ent[1].valid;
  assign front_in_order   = slot_ent[0].deadline <= slot_ent[1].deadline;
  assign burst_open       = out_valid_o && !last_o;

  // Valid slots form a packed run starting at the head.
  `SDTQ_ASSERT(a_valid_packed, (valid_vec & (valid_vec + 1'b1)) == '0, "slot gap")
  // The two front slots stay in deadline order.
  `SDTQ_ASSERT_IMP(a_head_sorted, front_both_valid, front_in_order, "head unsorted")
  // A pending non-final fired result keeps new requests out.
  `SDTQ_ASSERT_IMP(a_fire_blocks, burst_open, !in_ready_o, "request taken mid-burst")

endmodule

// ===== rtl/sdtq_cell.sv =====
`timescale 1ns / 1ps

module sdtq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sdtq_pkg::slot_cmd_t cmd_i,
  input  logic               shift_sel_i,
  input  sdtq_pkg::entry_t   left_i,
  input  logic               left_keep_i,
  input  sdtq_pkg::entry_t   right_i,
  output sdtq_pkg::entry_t   entry_o,
  output logic               keep_o
);

  logic                          valid_q, valid_d;
  logic [sdtq_pkg::SecW-1:0]     deadline_q, deadline_d;
  logic [sdtq_pkg::IdW-1:0]      owner_q, owner_d;

  // Keep the own entry on insert when it is due no later than the new one.
  assign keep_o = valid_q && (deadline_q <= cmd_i.deadline);

  assign entry_o.valid    = valid_q;
  assign entry_o.deadline = deadline_q;
  assign entry_o.owner    = owner_q;

  always_comb begin
    valid_d    = valid_q;
    deadline_d = deadline_q;
    owner_d    = owner_q;
    if (cmd_i.shift && shift_sel_i) begin
      valid_d    = right_i.valid;
      deadline_d = right_i.deadline;
      owner_d    = right_i.owner;
    end else if (cmd_i.insert && !keep_o) begin
      if (left_keep_i) begin
        valid_d    = 1'b1;
        deadline_d = cmd_i.deadline;
        owner_d    = cmd_i.owner;
      end else begin
        valid_d    = left_i.valid;
        deadline_d = left_i.deadline;
        owner_d    = left_i.owner;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    deadline_q <= deadline_d;
    owner_q    <= owner_d;
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int unsigned QueueDepth    = 16;
  localparam int unsigned ClkPeriod     = 8;
  localparam int unsigned CycleLimit    = 200_000;
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned IdlePct       = 13;

  // The package has no code for the fourth operation value; the block treats it as a no-op.
  localparam logic [sdtq_pkg::OpW-1:0] OpUnknown = 2'd3;

  // One result as it leaves the block.
  typedef struct packed {
    logic                          kind;
    logic [sdtq_pkg::IdW-1:0]      fired_id;
    logic                          status;
    logic                          nonempty;
    logic [sdtq_pkg::TmoW-1:0]     min_timeout;
    logic                          last;
  } timer_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                             in_valid_i  = 1'b0;
  logic                             in_ready_o;
  logic [sdtq_pkg::OpW-1:0]         operation_i = '0;
  logic [sdtq_pkg::DelayW-1:0]      delay_i     = '0;
  logic [sdtq_pkg::IdW-1:0]         task_id_i   = '0;
  logic                             out_valid_o;
  logic                             out_ready_i = 1'b0;
  logic                             kind_o;
  logic [sdtq_pkg::IdW-1:0]         fired_id_o;
  logic                             status_o;
  logic                             queue_nonempty_o;
  logic [sdtq_pkg::TmoW-1:0]        min_timeout_o;
  logic                             last_o;

  // Predicted timer state: entries 0..timer_count-1 in deadline order.
  logic [sdtq_pkg::SecW-1:0]        timer_now = '0;
  logic [sdtq_pkg::SecW-1:0]        timer_deadline [QueueDepth];
  logic [sdtq_pkg::IdW-1:0]         timer_owner    [QueueDepth];
  int unsigned                      timer_count = 0;

  timer_result_t                    pending_results [$];

  // Stimulus knobs, changed by the tests between requests.
  bit                  tx_gaps_on    = 1'b1;
  bit                  rx_stalls_on  = 1'b1;
  bit                  rx_hold_req   = 1'b0;
  bit                  rx_hold_taken = 1'b0;
  int unsigned         rx_hold_left  = 0;

  int unsigned         cycle_count   = 0;
  int unsigned         error_count   = 0;
  int unsigned         requests_seen = 0;
  int unsigned         results_seen  = 0;
  int unsigned         fires_seen    = 0;
  int unsigned         adds_refused  = 0;
  int unsigned         deepest_queue = 0;

  sorted_deadline_timer_queue #(
    .QUEUE_DEPTH(QueueDepth)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .delay_i          (delay_i),
    .task_id_i        (task_id_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .fired_id_o       (fired_id_o),
    .status_o         (status_o),
    .queue_nonempty_o (queue_nonempty_o),
    .min_timeout_o    (min_timeout_o),
    .last_o           (last_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Timer queue predictor
  // ---------------------------------------------------------------------------

  function automatic void drop_timer(int unsigned pos);
    for (int unsigned k = pos; k + 1 < timer_count; k++) begin
      timer_deadline[k] = timer_deadline[k + 1];
      timer_owner[k]    = timer_owner[k + 1];
    end
    timer_count--;
  endfunction

  // Acknowledge: report the time left to the head deadline, clamped at zero and at the result width.
  function automatic void push_ack(logic status);
    timer_result_t             res;
    logic [sdtq_pkg::SecW-1:0] left;
    res             = '0;
    res.kind        = sdtq_pkg::KIND_ACK;
    res.status      = status;
    res.nonempty    = (timer_count != 0);
    res.last        = 1'b1;
    if (timer_count != 0 && timer_deadline[0] > timer_now) begin
      left            = timer_deadline[0] - timer_now;
      res.min_timeout = (left > sdtq_pkg::SecW'(16'hFFFF)) ? 16'hFFFF
                                                           : left[sdtq_pkg::TmoW-1:0];
    end
    pending_results.push_back(res);
  endfunction

  function automatic void predict_timer_results(logic [sdtq_pkg::OpW-1:0] op,
                                                logic [sdtq_pkg::DelayW-1:0] dly,
                                                logic [sdtq_pkg::IdW-1:0] id);
    timer_result_t             res;
    logic [sdtq_pkg::SecW:0]   sum;
    logic [sdtq_pkg::SecW-1:0] dl;
    int unsigned               pos;
    int unsigned               fired;
    case (op)
      sdtq_pkg::OP_TICK: begin
        if (timer_now != {sdtq_pkg::SecW{1'b1}}) timer_now++;
        fired = 0;
        // Fire every due entry, head first, up to the per-tick limit.
        while (fired < sdtq_pkg::MaxFire && timer_count != 0 &&
               timer_deadline[0] <= timer_now) begin
          res          = '0;
          res.kind     = sdtq_pkg::KIND_FIRED;
          res.fired_id = timer_owner[0];
          res.status   = sdtq_pkg::STATUS_OK;
          drop_timer(0);
          fired++;
          res.nonempty = (timer_count != 0);
          res.last     = !(fired < sdtq_pkg::MaxFire && timer_count != 0 &&
                           timer_deadline[0] <= timer_now);
          pending_results.push_back(res);
          fires_seen++;
        end
        if (fired == 0) push_ack(sdtq_pkg::STATUS_OK);
      end
      sdtq_pkg::OP_ADD: begin
        if (timer_count >= QueueDepth) begin
          adds_refused++;
          push_ack(sdtq_pkg::STATUS_FULL);
        end else begin
          sum = {1'b0, timer_now} + (sdtq_pkg::SecW + 1)'(dly);
          dl  = sum[sdtq_pkg::SecW] ? {sdtq_pkg::SecW{1'b1}} : sum[sdtq_pkg::SecW-1:0];
          // Insert after every entry with an equal or earlier deadline.
          pos = 0;
          while (pos < timer_count && timer_deadline[pos] <= dl) pos++;
          for (int unsigned k = timer_count; k > pos; k--) begin
            timer_deadline[k] = timer_deadline[k - 1];
            timer_owner[k]    = timer_owner[k - 1];
          end
          timer_deadline[pos] = dl;
          timer_owner[pos]    = id;
          timer_count++;
          if (timer_count > deepest_queue) deepest_queue = timer_count;
          push_ack(sdtq_pkg::STATUS_OK);
        end
      end
      sdtq_pkg::OP_DELETE: begin
        pos = 0;
        while (pos < timer_count) begin
          if (timer_owner[pos] == id) drop_timer(pos);
          else pos++;
        end
        push_ack(sdtq_pkg::STATUS_OK);
      end
      default: push_ack(sdtq_pkg::STATUS_OK);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request monitor and result checker, both at the rising edge
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    timer_result_t want;
    if (rst_ni) begin
      // Predict first so a result on the same edge could still find its entry.
      if (in_valid_i && in_ready_o) begin
        predict_timer_results(operation_i, delay_i, task_id_i);
        requests_seen++;
      end
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual kind %0h id %0h",
                   $time, kind_o, fired_id_o);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind",           want.kind,        kind_o);
          check_field("fired_id",       want.fired_id,    fired_id_o);
          check_field("status",         want.status,      status_o);
          check_field("queue_nonempty", want.nonempty,    queue_nonempty_o);
          check_field("min_timeout",    want.min_timeout, min_timeout_o);
          check_field("last",           want.last,        last_o);
        end
      end
    end
  end

  // Guard against a hung block.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t ns: run stopped at the cycle limit, %0d results outstanding",
               $time, pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // Result receiver: hold off once for a counted stretch on demand, else stall at random when stalls are on.
  always @(negedge clk_i) begin
    if (rx_hold_req && !rx_hold_taken) begin
      rx_hold_taken <= 1'b1;
      rx_hold_left  <= HoldOffCycles - 1;
      out_ready_i   <= 1'b0;
    end else if (rx_hold_left != 0) begin
      out_ready_i  <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_stalls_on) begin
      out_ready_i  <= ($urandom_range(0, 99) >= IdlePct);
    end else begin
      out_ready_i  <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------

  // Offer one request and return at the edge that accepts it; valid stays up
  // so a back-to-back request only swaps the payload.
  task automatic send_request(logic [sdtq_pkg::OpW-1:0] op,
                              logic [sdtq_pkg::DelayW-1:0] dly,
                              logic [sdtq_pkg::IdW-1:0] id);
    @(negedge clk_i);
    while (tx_gaps_on && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    delay_i     <= dly;
    task_id_i   <= id;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Mostly a small pool of ids so deletes and equal owners hit; sometimes any id.
  function automatic logic [sdtq_pkg::IdW-1:0] random_task_id();
    return ($urandom_range(0, 3) == 0) ? sdtq_pkg::IdW'($urandom_range(0, 255))
                                       : sdtq_pkg::IdW'($urandom_range(0, 5));
  endfunction

  task automatic send_random_request(int unsigned add_pct);
    int unsigned                  roll;
    logic [sdtq_pkg::OpW-1:0]     op;
    logic [sdtq_pkg::DelayW-1:0]  dly;
    logic [sdtq_pkg::IdW-1:0]     id;
    roll = $urandom_range(0, 99);
    // Fields that the operation ignores still carry random bits.
    dly  = sdtq_pkg::DelayW'($urandom_range(0, 65535));
    id   = sdtq_pkg::IdW'($urandom_range(0, 255));
    if (roll < 5) begin
      op = OpUnknown;
    end else if (roll < 5 + add_pct) begin
      op = sdtq_pkg::OP_ADD;
      // Short delays keep entries firing; a few long ones exercise the full range.
      if ($urandom_range(0, 9) != 0) dly = sdtq_pkg::DelayW'($urandom_range(0, 6));
      id = random_task_id();
    end else if (roll < 17 + add_pct) begin
      op = sdtq_pkg::OP_DELETE;
      if (timer_count != 0 && $urandom_range(0, 3) != 0)
        id = timer_owner[$urandom_range(0, timer_count - 1)];
      else
        id = random_task_id();
    end else begin
      op = sdtq_pkg::OP_TICK;
    end
    send_request(op, dly, id);
  endtask

  // Drop valid and wait until every predicted result has come out.
  task automatic wait_results_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty queue, unknown operation, absent delete, zero and longest delay.
  task automatic test_empty_and_basic_ops();
    send_request(sdtq_pkg::OP_TICK,   16'h0000, 8'h00);
    send_request(OpUnknown,           16'hFFFF, 8'hFF);
    send_request(sdtq_pkg::OP_DELETE, 16'h0000, 8'h77);
    send_request(sdtq_pkg::OP_ADD,    16'h0000, 8'h00);
    send_request(sdtq_pkg::OP_ADD,    16'hFFFF, 8'hFF);
    send_request(sdtq_pkg::OP_ADD,    16'h0007, 8'h3C);
    send_request(OpUnknown,           16'h1234, 8'hC3);
    send_request(sdtq_pkg::OP_TICK,   16'hAAAA, 8'h55);
    send_request(sdtq_pkg::OP_DELETE, 16'h5555, 8'hFF);
    send_request(sdtq_pkg::OP_DELETE, 16'h0000, 8'h3C);
    wait_results_drained();
  endtask

  // Fill every slot with equal deadlines, refuse one more, then fire all on one tick.
  task automatic test_full_queue_and_mass_fire();
    for (int unsigned k = 0; k < QueueDepth; k++)
      send_request(sdtq_pkg::OP_ADD, 16'h0001, sdtq_pkg::IdW'(k * 8'h11));
    send_request(sdtq_pkg::OP_ADD,  16'h0002, 8'hEE);
    send_request(sdtq_pkg::OP_TICK, 16'h0000, 8'h00);
    wait_results_drained();
  endtask

  task automatic test_random_traffic(int unsigned count, int unsigned add_pct);
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    for (int unsigned n = 0; n < count; n++) send_random_request(add_pct);
    wait_results_drained();
  endtask

  // A long stretch with no idling on either side.
  task automatic test_back_to_back(int unsigned count);
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    for (int unsigned n = 0; n < count; n++) send_random_request(40);
    wait_results_drained();
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // Load due entries, then hold the receiver off while requests keep coming.
  task automatic test_result_backpressure(int unsigned count);
    for (int unsigned k = 0; k < 6; k++)
      send_request(sdtq_pkg::OP_ADD, 16'h0001, random_task_id());
    rx_hold_req = 1'b1;
    send_request(sdtq_pkg::OP_TICK, 16'h0000, 8'h00);
    for (int unsigned n = 0; n < count; n++) send_random_request(35);
    wait_results_drained();
  endtask

  initial begin
    int unsigned missing;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_and_basic_ops();
    test_full_queue_and_mass_fire();
    test_random_traffic(150, 25);
    test_random_traffic(150, 45);
    test_back_to_back(100);
    test_result_backpressure(34);

    // Let any stray result show up before the verdict.
    repeat (DrainCycles) @(posedge clk_i);
    missing = pending_results.size();
    if (missing != 0) begin
      $display("%0t ns: results missing, expected %0d more, actual 0", $time, missing);
    end

    $display("Ran %0d requests through the timer queue: %0d results, %0d timers fired,",
             requests_seen, results_seen, fires_seen);
    $display("%0d adds refused on a full queue, up to %0d entries pending, %0d mismatches.",
             adds_refused, deepest_queue, error_count);
    if (error_count == 0 && missing == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/sdtq_pkg.sv
rtl/sdtq_cell.sv
rtl/sorted_deadline_timer_queue.sv
sim/tb.sv
